### rtl/bspb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the brush stroke pixel blender.
// No dependencies; used by the channel interfaces and the top level.
package bspb_pkg;

    localparam int unsigned CH_W = 8;

    // Fixed-point denominators of the blend stages and the edge keep limit
    localparam int unsigned SHADOW_DEN = 25500;
    localparam int unsigned TINT_DEN   = 255;
    localparam int unsigned EDGE_DEN   = 65280;
    localparam int unsigned KEEP_MAX   = 256;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_EDGE_KEEP      = 3'd0,
        CFG_RELIEF_PERCENT = 3'd1,
        CFG_SHADOW_PERCENT = 3'd2,
        CFG_SHADOW_ENABLE  = 3'd3,
        CFG_TINT_ENABLE    = 3'd4,
        CFG_ALPHA_ENABLE   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [CH_W-1:0] in_red;
        logic [CH_W-1:0] in_green;
        logic [CH_W-1:0] in_blue;
        logic [CH_W-1:0] in_alpha;
        logic [CH_W-1:0] shadow_level;
        logic [CH_W-1:0] brush_level;
        logic [CH_W-1:0] brush_tint;
        logic [CH_W-1:0] relief_level;
        logic            relief_applies;
        logic [CH_W-1:0] paint_red;
        logic [CH_W-1:0] paint_green;
        logic [CH_W-1:0] paint_blue;
    } t_pix_in;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic [CH_W-1:0] out_alpha;
    } t_pix_out;

endpackage

### rtl/bspb_in_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one canvas pixel plus brush data.
// Depends on bspb_pkg for the payload type.
interface bspb_in_if;
    logic              valid;
    logic              ready;
    bspb_pkg::t_pix_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/bspb_out_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one blended canvas pixel.
// Depends on bspb_pkg for the payload type.
interface bspb_out_if;
    logic               valid;
    logic               ready;
    bspb_pkg::t_pix_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/brush_stroke_pixel_blend.sv
`timescale 1ns / 1ps
// Brush stroke pixel blender: nine-stage pipeline, top level.
// Depends on bspb_pkg, bspb_in_if and bspb_out_if.
//
// Usage
//   i_pix  : one canvas pixel with its shadow, brush, tint, relief and paint
//            values per transfer (valid/ready, taken when both are high).
//   o_pix  : the pixel after the stroke, one transfer per input transfer,
//            in input order.
//   i_cfg_*: register writes, index 0..5 as listed in bspb_pkg::t_cfg_idx;
//            other indexes are ignored. Write only while the pipe is empty.
//   Output: o_pix.valid shows the pixel once it reaches the stage 8 register.
//   Throughput: one pixel per cycle while o_pix.ready is high. The divides
//   by 25500, 255 and 65280 are exact reciprocal multiplies.
//   Stall: each stage loads when it is empty or its successor moves, so
//   bubbles are squeezed out and i_pix.ready drops only when all nine
//   stages hold data and o_pix.ready is low. Nothing is dropped or repeated.
//   Reset: synchronous, active low; empties the pipe, edge_keep = 256,
//   all other config registers 0.
module brush_stroke_pixel_blend (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bspb_in_if.sink               i_pix,
    bspb_out_if.source            o_pix,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [8:0]            i_cfg_data
);

    localparam int NSTG = 9;
    localparam int LAST = NSTG - 1;

    // Reciprocals: floor(x/D) == (x*ceil(2^K/D)) >> K for the x ranges used
    localparam int K_SH   = 38;
    localparam int K_TINT = 24;
    localparam int K_EDGE = 40;
    localparam logic [63:0] M_SH   = ((64'd1 << K_SH) + 64'(bspb_pkg::SHADOW_DEN) - 64'd1)
                                     / 64'(bspb_pkg::SHADOW_DEN);
    localparam logic [63:0] M_TINT = ((64'd1 << K_TINT) + 64'(bspb_pkg::TINT_DEN) - 64'd1)
                                     / 64'(bspb_pkg::TINT_DEN);
    localparam logic [63:0] M_EDGE = ((64'd1 << K_EDGE) + 64'(bspb_pkg::EDGE_DEN) - 64'd1)
                                     / 64'(bspb_pkg::EDGE_DEN);

    typedef struct packed {
        logic [3:0][7:0]  ch;      // lanes 0..2 colour, lane 3 alpha
        logic [3:0][23:0] prod;
        logic [2:0][7:0]  pt;      // paint * h / 255
        logic [2:0][15:0] ptprod;
        logic [14:0]      f;
        logic [14:0]      f_al;
        logic [7:0]       tf;
        logic [7:0]       tf_al;
        logic [15:0]      ef;
        logic [15:0]      ef_al;
        logic [14:0]      q;
    } t_stg;

    // Config registers
    logic [8:0] r_edge_keep;
    logic [6:0] r_relief_pct;
    logic [6:0] r_shadow_pct;
    logic       r_shadow_en;
    logic       r_tint_en;
    logic       r_alpha_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_keep  <= 9'(bspb_pkg::KEEP_MAX);
            r_relief_pct <= '0;
            r_shadow_pct <= '0;
            r_shadow_en  <= 1'b0;
            r_tint_en    <= 1'b0;
            r_alpha_en   <= 1'b0;
        end else if (i_cfg_we) begin
            case (bspb_pkg::t_cfg_idx'(i_cfg_idx))
                bspb_pkg::CFG_EDGE_KEEP:      r_edge_keep  <= i_cfg_data;
                bspb_pkg::CFG_RELIEF_PERCENT: r_relief_pct <= i_cfg_data[6:0];
                bspb_pkg::CFG_SHADOW_PERCENT: r_shadow_pct <= i_cfg_data[6:0];
                bspb_pkg::CFG_SHADOW_ENABLE:  r_shadow_en  <= i_cfg_data[0];
                bspb_pkg::CFG_TINT_ENABLE:    r_tint_en    <= i_cfg_data[0];
                bspb_pkg::CFG_ALPHA_ENABLE:   r_alpha_en   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Constant dividers
    function automatic logic [7:0] div_sh(input logic [23:0] x);
        logic [46:0] p;
        p = 47'(x[22:0]) * 47'(M_SH[23:0]);
        return p[K_SH+7:K_SH];
    endfunction

    function automatic logic [7:0] div_tint(input logic [15:0] x);
        logic [32:0] p;
        p = 33'(x) * 33'(M_TINT[16:0]);
        return p[K_TINT+7:K_TINT];
    endfunction

    function automatic logic [7:0] div_edge(input logic [23:0] x);
        logic [48:0] p;
        p = 49'(x) * 49'(M_EDGE[24:0]);
        return p[K_EDGE+7:K_EDGE];
    endfunction

    // Pipeline registers and per-stage load enables
    t_stg             r_st  [NSTG];
    t_stg             n_st  [NSTG];
    logic [NSTG-1:0]  r_vld;
    logic [NSTG:0]    ld;

    always_comb begin
        ld[NSTG] = o_pix.ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            ld[k] = !r_vld[k] || ld[k+1];
        end
    end

    assign i_pix.ready = ld[0];

    always_comb begin
        logic        sh_on;
        logic        br_on;
        logic [14:0] d;
        logic [14:0] qr;
        logic [8:0]  keep;
        logic [8:0]  sum;

        // stage 0: operand setup; all factors reduce to identity when a step is off
        n_st[0] = r_st[0];
        n_st[0].ch[0] = i_pix.data.in_red;
        n_st[0].ch[1] = i_pix.data.in_green;
        n_st[0].ch[2] = i_pix.data.in_blue;
        n_st[0].ch[3] = i_pix.data.in_alpha;
        sh_on = r_shadow_en && (i_pix.data.shadow_level != '0);
        br_on = i_pix.data.brush_level != '0;
        d = 15'(i_pix.data.shadow_level) * 15'(r_shadow_pct);
        if (d > 15'(bspb_pkg::SHADOW_DEN)) begin
            d = 15'(bspb_pkg::SHADOW_DEN);
        end
        n_st[0].f    = sh_on ? 15'(bspb_pkg::SHADOW_DEN) - d : 15'(bspb_pkg::SHADOW_DEN);
        n_st[0].f_al = r_alpha_en ? n_st[0].f : 15'(bspb_pkg::SHADOW_DEN);
        n_st[0].tf   = (br_on && r_tint_en) ? 8'd255 - i_pix.data.brush_tint : 8'd255;
        n_st[0].tf_al = r_alpha_en ? n_st[0].tf : 8'd255;
        keep = (r_edge_keep > 9'(bspb_pkg::KEEP_MAX)) ? 9'(bspb_pkg::KEEP_MAX) : r_edge_keep;
        n_st[0].ef = br_on ? 16'(17'(8'd255 - i_pix.data.brush_level) * 17'(keep))
                           : 16'(bspb_pkg::EDGE_DEN);
        n_st[0].ef_al = r_alpha_en ? n_st[0].ef : 16'(bspb_pkg::EDGE_DEN);
        qr = 15'(i_pix.data.relief_level) * 15'(r_relief_pct);
        if (qr > 15'(bspb_pkg::SHADOW_DEN)) begin
            qr = 15'(bspb_pkg::SHADOW_DEN);
        end
        n_st[0].q = i_pix.data.relief_applies ? qr : 15'd0;
        n_st[0].ptprod[0] = 16'(i_pix.data.paint_red)   * 16'(i_pix.data.brush_level);
        n_st[0].ptprod[1] = 16'(i_pix.data.paint_green) * 16'(i_pix.data.brush_level);
        n_st[0].ptprod[2] = 16'(i_pix.data.paint_blue)  * 16'(i_pix.data.brush_level);

        // stage 1: shadow multiply
        n_st[1] = r_st[0];
        for (int i = 0; i < 3; i++) begin
            n_st[1].prod[i] = 24'(r_st[0].ch[i]) * 24'(r_st[0].f);
        end
        n_st[1].prod[3] = 24'(r_st[0].ch[3]) * 24'(r_st[0].f_al);

        // stage 2: shadow divide, paint term divide
        n_st[2] = r_st[1];
        for (int i = 0; i < 4; i++) begin
            n_st[2].ch[i] = div_sh(r_st[1].prod[i]);
        end
        for (int j = 0; j < 3; j++) begin
            n_st[2].pt[j] = div_tint(r_st[1].ptprod[j]);
        end

        // stage 3: tint multiply
        n_st[3] = r_st[2];
        for (int i = 0; i < 3; i++) begin
            n_st[3].prod[i] = 24'(r_st[2].ch[i]) * 24'(r_st[2].tf);
        end
        n_st[3].prod[3] = 24'(r_st[2].ch[3]) * 24'(r_st[2].tf_al);

        // stage 4: tint divide
        n_st[4] = r_st[3];
        for (int i = 0; i < 4; i++) begin
            n_st[4].ch[i] = div_tint(r_st[3].prod[i][15:0]);
        end

        // stage 5: edge multiply
        n_st[5] = r_st[4];
        for (int i = 0; i < 3; i++) begin
            n_st[5].prod[i] = 24'(r_st[4].ch[i]) * 24'(r_st[4].ef);
        end
        n_st[5].prod[3] = 24'(r_st[4].ch[3]) * 24'(r_st[4].ef_al);

        // stage 6: edge divide, add paint, clamp
        n_st[6] = r_st[5];
        for (int j = 0; j < 3; j++) begin
            sum = 9'(div_edge(r_st[5].prod[j])) + 9'(r_st[5].pt[j]);
            n_st[6].ch[j] = sum[8] ? 8'd255 : sum[7:0];
        end
        n_st[6].ch[3] = div_edge(r_st[5].prod[3]);

        // stage 7: relief blend toward white, numerator
        n_st[7] = r_st[6];
        for (int j = 0; j < 3; j++) begin
            n_st[7].prod[j] = 24'(r_st[6].ch[j])
                              * 24'(15'(bspb_pkg::SHADOW_DEN) - r_st[6].q)
                              + ((24'(r_st[6].q) << 8) - 24'(r_st[6].q));
        end

        // stage 8: relief divide, output register
        n_st[8] = r_st[7];
        for (int j = 0; j < 3; j++) begin
            n_st[8].ch[j] = div_sh(r_st[7].prod[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSTG; k++) begin
            if (ld[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (ld[k]) begin
                    r_vld[k] <= (k == 0) ? i_pix.valid : r_vld[k-1];
                end
            end
        end
    end

    assign o_pix.valid          = r_vld[LAST];
    assign o_pix.data.out_red   = r_st[LAST].ch[0];
    assign o_pix.data.out_green = r_st[LAST].ch[1];
    assign o_pix.data.out_blue  = r_st[LAST].ch[2];
    assign o_pix.data.out_alpha = r_st[LAST].ch[3];

`ifndef NO_ASSERTIONS
    // A ready consumer never back-pressures the input
    a_ready_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.ready |-> i_pix.ready)
        else $error("input stalled while output ready");

    // Occupancy tracks transfers: nothing lost, nothing duplicated
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> $countones(r_vld) == $past($countones(r_vld))
                 + int'($past(i_pix.valid && i_pix.ready))
                 - int'($past(o_pix.valid && o_pix.ready)))
        else $error("pipeline occupancy mismatch");

    // A held middle stage keeps its contents
    a_mid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[4] && !ld[4]) |=> (r_vld[4] && $stable(r_st[4])))
        else $error("stalled stage changed");
`endif

endmodule
